@@ design/rsnh_pkg.sv @@
// Shared types, constants and the arithmetic micro-program for the ray and wall nearest-hit block.
`timescale 1ns / 1ps
package rsnh_pkg;

  localparam int CoordW  = 16;
  localparam int CountW  = 7;
  localparam int IdxW    = 6;
  localparam int StepW   = 5;
  localparam int OpW     = 18;
  localparam int ProdW   = 2 * OpW;
  localparam int AccW    = 56;
  localparam int CW      = 34;              // line constants c1, c2
  localparam int DetW    = 35;
  localparam int NumW    = 54;              // signed numerators and quotients
  localparam int QW      = NumW - 1;        // quotient magnitude
  localparam int RemW    = DetW;
  localparam int SqW     = 36;
  localparam int DivCntW = 6;
  localparam int ShlAmt  = CoordW + 1;      // split point of c1, c2
  localparam int WallW   = 4 * CoordW;

  localparam int InDataW = 168;
  localparam int OutDataW = 40;

  // input tdata field offsets
  localparam int InIdxLsb  = 0;
  localparam int InX1Lsb   = 6;
  localparam int InY1Lsb   = 22;
  localparam int InX2Lsb   = 38;
  localparam int InY2Lsb   = 54;
  localparam int InOxLsb   = 70;
  localparam int InOyLsb   = 86;
  localparam int InFarXLsb = 102;
  localparam int InFarYLsb = 118;
  localparam int InFcXLsb  = 134;
  localparam int InFcYLsb  = 150;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncCast  = 1'b1;

  localparam logic [StepW-1:0] StepSetupLast = 5'd2;
  localparam logic [StepW-1:0] StepWallFirst = 5'd3;
  localparam logic [StepW-1:0] StepWallLast  = 5'd15;
  localparam logic [StepW-1:0] StepDistFirst = 5'd16;
  localparam logic [StepW-1:0] StepDistLast  = 5'd22;

  // count 0 loads the divider, counts 1..QW shift one quotient bit each
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(QW);

  typedef enum logic [4:0] {
    MUL_NONE, MUL_A1_PX, MUL_B1_PY, MUL_A2_X1, MUL_B2_Y1, MUL_A1_B2, MUL_A2_B1,
    MUL_B2_C1H, MUL_B1_C2H, MUL_B2_C1L, MUL_B1_C2L,
    MUL_A1_C2H, MUL_A2_C1H, MUL_A1_C2L, MUL_A2_C1L,
    MUL_DX_DX, MUL_DY_DY, MUL_EX_EX, MUL_EY_EY, MUL_DX_FX, MUL_DY_FY
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_SHL_ADD
  } acc_op_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_C1, DST_C2, DST_DET, DST_NUMX, DST_NUMY, DST_DIST, DST_EDIST, DST_DOT
  } dst_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    dst_t     dst;
  } ucode_t;

  typedef struct packed {
    ucode_t              u;
    logic                wr_wall;
    logic                load_cast;
    logic                rd_wall;
    logic [CountW-1:0]   wall_idx;
    logic                div_load;
    logic                div_step;
    logic                update;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic in_box;
    logic take;
  } dp_stat_t;

  // The accumulator takes the product issued one step earlier.
  function automatic ucode_t ucode(input logic [StepW-1:0] step);
    ucode_t u;
    u = '{MUL_NONE, ACC_HOLD, DST_NONE};
    unique case (step)
      5'd0:  u = '{MUL_A1_PX,  ACC_HOLD,    DST_NONE};
      5'd1:  u = '{MUL_B1_PY,  ACC_LOAD,    DST_NONE};
      5'd2:  u = '{MUL_NONE,   ACC_ADD,     DST_C1};
      5'd3:  u = '{MUL_A2_X1,  ACC_HOLD,    DST_NONE};
      5'd4:  u = '{MUL_B2_Y1,  ACC_LOAD,    DST_NONE};
      5'd5:  u = '{MUL_A1_B2,  ACC_ADD,     DST_C2};
      5'd6:  u = '{MUL_A2_B1,  ACC_LOAD,    DST_NONE};
      5'd7:  u = '{MUL_B2_C1H, ACC_SUB,     DST_DET};
      5'd8:  u = '{MUL_B1_C2H, ACC_LOAD,    DST_NONE};
      5'd9:  u = '{MUL_B2_C1L, ACC_SUB,     DST_NONE};
      5'd10: u = '{MUL_B1_C2L, ACC_SHL_ADD, DST_NONE};
      5'd11: u = '{MUL_A1_C2H, ACC_SUB,     DST_NUMX};
      5'd12: u = '{MUL_A2_C1H, ACC_LOAD,    DST_NONE};
      5'd13: u = '{MUL_A1_C2L, ACC_SUB,     DST_NONE};
      5'd14: u = '{MUL_A2_C1L, ACC_SHL_ADD, DST_NONE};
      5'd15: u = '{MUL_NONE,   ACC_SUB,     DST_NUMY};
      5'd16: u = '{MUL_DX_DX,  ACC_HOLD,    DST_NONE};
      5'd17: u = '{MUL_DY_DY,  ACC_LOAD,    DST_NONE};
      5'd18: u = '{MUL_EX_EX,  ACC_ADD,     DST_DIST};
      5'd19: u = '{MUL_EY_EY,  ACC_LOAD,    DST_NONE};
      5'd20: u = '{MUL_DX_FX,  ACC_ADD,     DST_EDIST};
      5'd21: u = '{MUL_DY_FY,  ACC_LOAD,    DST_NONE};
      5'd22: u = '{MUL_NONE,   ACC_ADD,     DST_DOT};
      default: u = '{MUL_NONE, ACC_HOLD, DST_NONE};
    endcase
    return u;
  endfunction

endpackage

@@ design/rsnh_ctrl.sv @@
// Controller state machine: handshakes, wall loop, micro-program sequencing.
`timescale 1ns / 1ps
module rsnh_ctrl import rsnh_pkg::*; #(
  parameter int MAX_WALLS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_func,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_wdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SETUP  = 10'b0000000010,
    S_RDWALL = 10'b0000000100,
    S_MAC    = 10'b0000001000,
    S_DIV    = 10'b0000010000,
    S_CHECK  = 10'b0000100000,
    S_DIST   = 10'b0001000000,
    S_DECIDE = 10'b0010000000,
    S_NEXT   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [StepW-1:0]     step_r, step_nxt;
  logic [CountW-1:0]    idx_r, idx_nxt, idx_inc;
  logic [DivCntW-1:0]   div_cnt_r, div_cnt_nxt;
  logic [CountW-1:0]    count_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 first_ok, more_ok;

  assign idx_inc  = idx_r + 1'b1;
  assign first_ok = (count_r != '0);
  assign more_ok  = (int'(idx_inc) < int'(count_r)) && (int'(idx_inc) < MAX_WALLS);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    idx_nxt      = idx_r;
    div_cnt_nxt  = div_cnt_r;
    cmd          = '0;
    cmd.u        = '{MUL_NONE, ACC_HOLD, DST_NONE};
    cmd.wall_idx = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_func == FuncCast) begin
            cmd.load_cast = 1'b1;
            step_nxt      = '0;
            idx_nxt       = '0;
            state_nxt     = S_SETUP;
          end else begin
            cmd.wr_wall = 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd.u    = ucode(step_r);
        step_nxt = step_r + 1'b1;
        if (step_r == StepSetupLast) begin
          state_nxt = first_ok ? S_RDWALL : S_DONE;
        end
      end
      S_RDWALL: begin
        cmd.rd_wall = 1'b1;
        step_nxt    = StepWallFirst;
        state_nxt   = S_MAC;
      end
      S_MAC: begin
        cmd.u    = ucode(step_r);
        step_nxt = step_r + 1'b1;
        if (step_r == StepWallLast) begin
          div_cnt_nxt = '0;
          // parallel wall: skip
          state_nxt   = stat.det_zero ? S_NEXT : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_load = (div_cnt_r == '0);
        cmd.div_step = (div_cnt_r != '0);
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DivLast) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        step_nxt  = StepDistFirst;
        state_nxt = stat.in_box ? S_DIST : S_NEXT;
      end
      S_DIST: begin
        cmd.u    = ucode(step_r);
        step_nxt = step_r + 1'b1;
        if (step_r == StepDistLast) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.update = stat.take;
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        idx_nxt   = idx_inc;
        state_nxt = more_ok ? S_RDWALL : S_DONE;
      end
      S_DONE: begin
        // hold until the output slot is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      idx_r       <= '0;
      div_cnt_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

endmodule

@@ design/rsnh_dp.sv @@
// Datapath: wall memory, shared multiplier and accumulator, two-lane divider, hit tests.
`timescale 1ns / 1ps
module rsnh_dp import rsnh_pkg::*; #(
  parameter int MAX_WALLS = 64
) (
  input  logic                clk,
  input  logic [InDataW-1:0]  in_data,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic [OutDataW-1:0] out_data,
  output logic                out_flag
);

  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;

  logic [WallW-1:0] mem [MAX_WALLS];
  logic [WallW-1:0] wall_q_r;

  logic [IdxW-1:0]          wr_idx;
  logic [AW+IdxW-1:0]       wr_idx_ext;
  logic [AW+CountW-1:0]     rd_idx_ext;
  logic                     wr_ok;

  assign wr_idx     = in_data[InIdxLsb +: IdxW];
  assign wr_idx_ext = (AW+IdxW)'(wr_idx);
  assign rd_idx_ext = (AW+CountW)'(cmd.wall_idx);
  assign wr_ok      = int'(wr_idx) < MAX_WALLS;

  always_ff @(posedge clk) begin
    if (cmd.wr_wall && wr_ok) begin
      mem[wr_idx_ext[AW-1:0]] <= {in_data[InY2Lsb +: CoordW], in_data[InX2Lsb +: CoordW],
                                  in_data[InY1Lsb +: CoordW], in_data[InX1Lsb +: CoordW]};
    end
    if (cmd.rd_wall) begin
      wall_q_r <= mem[rd_idx_ext[AW-1:0]];
    end
  end

  // cast registers
  logic signed [CoordW-1:0] px_r, py_r, fx_r, fy_r, best_x_r, best_y_r;
  logic signed [CoordW:0]   a1_r, b1_r;
  logic                     found_r;
  logic [IdxW-1:0]          which_r;
  logic signed [CoordW-1:0] in_ox, in_oy, in_farx, in_fary;

  assign in_ox   = in_data[InOxLsb +: CoordW];
  assign in_oy   = in_data[InOyLsb +: CoordW];
  assign in_farx = in_data[InFarXLsb +: CoordW];
  assign in_fary = in_data[InFarYLsb +: CoordW];

  // wall terms
  logic signed [CoordW-1:0] x1w, y1w, x2w, y2w;
  logic signed [CoordW:0]   a2, b2;

  assign x1w = wall_q_r[0 +: CoordW];
  assign y1w = wall_q_r[CoordW +: CoordW];
  assign x2w = wall_q_r[2*CoordW +: CoordW];
  assign y2w = wall_q_r[3*CoordW +: CoordW];
  assign a2  = (CoordW+1)'(y2w) - (CoordW+1)'(y1w);
  assign b2  = (CoordW+1)'(x1w) - (CoordW+1)'(x2w);

  logic signed [CW-1:0]     c1_r, c2_r;
  logic signed [DetW-1:0]   det_r;
  logic signed [NumW-1:0]   numx_r, numy_r;
  logic signed [SqW-1:0]    dist_r, edist_r, dot_r;
  logic signed [ProdW-1:0]  prod_r;
  logic signed [AccW-1:0]   acc_r, acc_nxt, prod_ext;

  // c split into a signed high part and an unsigned low part
  logic signed [CoordW:0]   c1h, c2h;
  logic signed [OpW-1:0]    c1l, c2l;
  assign c1h = c1_r[CW-1:ShlAmt];
  assign c2h = c2_r[CW-1:ShlAmt];
  assign c1l = {1'b0, c1_r[ShlAmt-1:0]};
  assign c2l = {1'b0, c2_r[ShlAmt-1:0]};

  // divider
  logic [QW-1:0]    nx_r, ny_r;
  logic [RemW-1:0]  remx_r, remy_r;
  logic [DetW-1:0]  dm_r;
  logic             negx_r, negy_r;
  logic [NumW-1:0]  magx, magy;
  logic [DetW-1:0]  magd;
  logic [RemW:0]    trial_x, trial_y, diff_x, diff_y;
  logic             ge_x, ge_y;

  assign magx    = numx_r[NumW-1] ? NumW'(-numx_r) : NumW'(numx_r);
  assign magy    = numy_r[NumW-1] ? NumW'(-numy_r) : NumW'(numy_r);
  assign magd    = det_r[DetW-1] ? DetW'(-det_r) : DetW'(det_r);
  assign trial_x = {remx_r, nx_r[QW-1]};
  assign trial_y = {remy_r, ny_r[QW-1]};
  assign diff_x  = trial_x - {1'b0, dm_r};
  assign diff_y  = trial_y - {1'b0, dm_r};
  assign ge_x    = trial_x >= {1'b0, dm_r};
  assign ge_y    = trial_y >= {1'b0, dm_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      nx_r   <= magx[QW-1:0];
      ny_r   <= magy[QW-1:0];
      dm_r   <= magd;
      remx_r <= '0;
      remy_r <= '0;
      negx_r <= numx_r[NumW-1] ^ det_r[DetW-1];
      negy_r <= numy_r[NumW-1] ^ det_r[DetW-1];
    end else if (cmd.div_step) begin
      remx_r <= ge_x ? diff_x[RemW-1:0] : trial_x[RemW-1:0];
      remy_r <= ge_y ? diff_y[RemW-1:0] : trial_y[RemW-1:0];
      nx_r   <= {nx_r[QW-2:0], ge_x};
      ny_r   <= {ny_r[QW-2:0], ge_y};
    end
  end

  logic signed [NumW-1:0] tx, ty;
  assign tx = negx_r ? -$signed({1'b0, nx_r}) : $signed({1'b0, nx_r});
  assign ty = negy_r ? -$signed({1'b0, ny_r}) : $signed({1'b0, ny_r});

  // bounding box, strict, with the flat-box cases
  logic signed [CoordW-1:0] xmin, xmax, ymin, ymax;
  logic xin, yin, box_ok;
  assign xmin = (x1w < x2w) ? x1w : x2w;
  assign xmax = (x1w > x2w) ? x1w : x2w;
  assign ymin = (y1w < y2w) ? y1w : y2w;
  assign ymax = (y1w > y2w) ? y1w : y2w;
  assign xin  = (tx > NumW'(xmin)) && (tx < NumW'(xmax));
  assign yin  = (ty > NumW'(ymin)) && (ty < NumW'(ymax));

  always_comb begin
    priority if (xmax == xmin) begin
      box_ok = yin;
    end else if (ymax == ymin) begin
      box_ok = xin;
    end else begin
      box_ok = xin && yin;
    end
  end

  logic signed [CoordW-1:0] tx16, ty16;
  logic signed [CoordW:0]   dx, dy, ex, ey;
  assign tx16 = tx[CoordW-1:0];
  assign ty16 = ty[CoordW-1:0];
  assign dx   = (CoordW+1)'(tx16) - (CoordW+1)'(px_r);
  assign dy   = (CoordW+1)'(ty16) - (CoordW+1)'(py_r);
  assign ex   = (CoordW+1)'(best_x_r) - (CoordW+1)'(px_r);
  assign ey   = (CoordW+1)'(best_y_r) - (CoordW+1)'(py_r);

  assign stat.det_zero = (det_r == '0);
  assign stat.in_box   = box_ok;
  assign stat.take     = (dist_r < edist_r) && (dot_r > 0);

  // multiplier operand select
  logic signed [OpW-1:0] opa, opb;
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd.u.mul)
      MUL_NONE:   begin opa = '0;           opb = '0;           end
      MUL_A1_PX:  begin opa = OpW'(a1_r);   opb = OpW'(px_r);   end
      MUL_B1_PY:  begin opa = OpW'(b1_r);   opb = OpW'(py_r);   end
      MUL_A2_X1:  begin opa = OpW'(a2);     opb = OpW'(x1w);    end
      MUL_B2_Y1:  begin opa = OpW'(b2);     opb = OpW'(y1w);    end
      MUL_A1_B2:  begin opa = OpW'(a1_r);   opb = OpW'(b2);     end
      MUL_A2_B1:  begin opa = OpW'(a2);     opb = OpW'(b1_r);   end
      MUL_B2_C1H: begin opa = OpW'(b2);     opb = OpW'(c1h);    end
      MUL_B1_C2H: begin opa = OpW'(b1_r);   opb = OpW'(c2h);    end
      MUL_B2_C1L: begin opa = OpW'(b2);     opb = c1l;          end
      MUL_B1_C2L: begin opa = OpW'(b1_r);   opb = c2l;          end
      MUL_A1_C2H: begin opa = OpW'(a1_r);   opb = OpW'(c2h);    end
      MUL_A2_C1H: begin opa = OpW'(a2);     opb = OpW'(c1h);    end
      MUL_A1_C2L: begin opa = OpW'(a1_r);   opb = c2l;          end
      MUL_A2_C1L: begin opa = OpW'(a2);     opb = c1l;          end
      MUL_DX_DX:  begin opa = OpW'(dx);     opb = OpW'(dx);     end
      MUL_DY_DY:  begin opa = OpW'(dy);     opb = OpW'(dy);     end
      MUL_EX_EX:  begin opa = OpW'(ex);     opb = OpW'(ex);     end
      MUL_EY_EY:  begin opa = OpW'(ey);     opb = OpW'(ey);     end
      MUL_DX_FX:  begin opa = OpW'(dx);     opb = OpW'(fx_r);   end
      MUL_DY_FY:  begin opa = OpW'(dy);     opb = OpW'(fy_r);   end
      default:    begin opa = '0;           opb = '0;           end
    endcase
  end

  assign prod_ext = AccW'(prod_r);

  always_comb begin
    unique case (cmd.u.acc)
      ACC_HOLD:    acc_nxt = acc_r;
      ACC_LOAD:    acc_nxt = prod_ext;
      ACC_ADD:     acc_nxt = acc_r + prod_ext;
      ACC_SUB:     acc_nxt = acc_r - prod_ext;
      ACC_SHL_ADD: acc_nxt = (acc_r <<< ShlAmt) + prod_ext;
      default:     acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    acc_r  <= acc_nxt;
    unique case (cmd.u.dst)
      DST_NONE:  ;
      DST_C1:    c1_r    <= acc_nxt[CW-1:0];
      DST_C2:    c2_r    <= acc_nxt[CW-1:0];
      DST_DET:   det_r   <= acc_nxt[DetW-1:0];
      DST_NUMX:  numx_r  <= acc_nxt[NumW-1:0];
      DST_NUMY:  numy_r  <= acc_nxt[NumW-1:0];
      DST_DIST:  dist_r  <= acc_nxt[SqW-1:0];
      DST_EDIST: edist_r <= acc_nxt[SqW-1:0];
      DST_DOT:   dot_r   <= acc_nxt[SqW-1:0];
      default:   ;
    endcase
  end

  // cast state and best hit
  logic signed [CoordW-1:0] hit_x_r, hit_y_r;
  logic                     hit_found_r;
  logic [IdxW-1:0]          hit_wall_r;

  always_ff @(posedge clk) begin
    if (cmd.load_cast) begin
      px_r     <= in_ox;
      py_r     <= in_oy;
      fx_r     <= in_data[InFcXLsb +: CoordW];
      fy_r     <= in_data[InFcYLsb +: CoordW];
      a1_r     <= (CoordW+1)'(in_fary) - (CoordW+1)'(in_oy);
      b1_r     <= (CoordW+1)'(in_ox) - (CoordW+1)'(in_farx);
      best_x_r <= in_farx;
      best_y_r <= in_fary;
      found_r  <= 1'b0;
      which_r  <= '0;
    end else if (cmd.update) begin
      best_x_r <= tx16;
      best_y_r <= ty16;
      found_r  <= 1'b1;
      which_r  <= cmd.wall_idx[IdxW-1:0];
    end
    if (cmd.out_load) begin
      hit_x_r     <= best_x_r;
      hit_y_r     <= best_y_r;
      hit_found_r <= found_r;
      hit_wall_r  <= which_r;
    end
  end

  assign out_data = {2'b00, hit_wall_r, hit_y_r, hit_x_r};
  assign out_flag = hit_found_r;

endmodule

@@ design/ray_segment_nearest_hit.sv @@
// Top level of the ray against wall segments nearest-hit block.
//
//  channel | direction | handshake                 | payload
//  in_     | slave     | in_tvalid / in_tready     | in_tdata (walls, ray), in_tuser (func)
//  out_    | master    | out_tvalid / out_tready   | out_tdata (hit point, wall), out_tuser
//  cfg_    | write     | cfg_we                    | cfg_wdata (wall_count)
//
// A wall write is stored while the controller stays idle. For each examined wall a
// cast runs 13 steps of the shared 18x18 multiplier and the bit-serial divider, and
// 7 more multiplier steps when the hit lies in the box.
// Reset clears the controller, wall_count and the output valid; the wall memory
// holds garbage until written. A waiting result does not block input; a finished
// cast holds until the output register is free.
`timescale 1ns / 1ps
module ray_segment_nearest_hit import rsnh_pkg::*; #(
  parameter int MAX_WALLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // wall_index, wall_x1, wall_y1, wall_x2, wall_y2, origin_x, origin_y,
  // far_x, far_y, facing_x, facing_y, zero pad
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,    // func
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,   // hit_x, hit_y, hit_wall, zero pad
  output logic                out_tuser,   // hit_found
  input  logic                cfg_we,
  input  logic [CountW-1:0]   cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rsnh_ctrl #(
    .MAX_WALLS (MAX_WALLS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rsnh_dp #(
    .MAX_WALLS (MAX_WALLS)
  ) u_dp (
    .clk      (clk),
    .in_data  (in_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_tdata),
    .out_flag (out_tuser)
  );

endmodule

@@ design/rsnh_chk.sv @@
// Port-level checker for the nearest-hit block and its bind.
`timescale 1ns / 1ps
module rsnh_chk import rsnh_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                in_tuser,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_miss_wall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[37:32] == '0)
    else $error("wall index set on a miss");

  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FuncCast) |=> !in_tready)
    else $error("input taken during a cast");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FuncWrite) |=> in_tready)
    else $error("wall write stalled the input");

endmodule

bind ray_segment_nearest_hit rsnh_chk u_rsnh_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the ray against wall segments nearest-hit block.
`timescale 1ns / 1ps

typedef struct {
  logic                func;
  logic [5:0]          idx;
  logic signed [15:0]  x1, y1, x2, y2;
  logic signed [15:0]  ox, oy, fx, fy, cx, cy;
} ray_item_t;

typedef struct {
  logic [15:0] hx, hy;
  logic        found;
  logic [5:0]  wall;
} hit_t;

class hit_scoreboard;
  longint wx1[64], wy1[64], wx2[64], wy2[64];
  int     walls_used;
  hit_t   hits_due[$];
  int     mismatches;

  function new();
    walls_used = 0;
    mismatches = 0;
  endfunction

  function void set_count(logic [6:0] v);
    walls_used = (v > 64) ? 64 : v;
  endfunction

  // Store a wall, or predict the nearest hit of a cast.
  function void note_input(ray_item_t it);
    longint px, py, rx, ry, a1, b1, c1, a2, b2, c2, det, tx, ty, dx, dy;
    longint xmin, xmax, ymin, ymax;
    bit     xin, yin, boxed;
    hit_t   h;
    if (it.func == rsnh_pkg::FuncWrite) begin
      wx1[it.idx] = it.x1; wy1[it.idx] = it.y1;
      wx2[it.idx] = it.x2; wy2[it.idx] = it.y2;
      return;
    end
    px = it.ox; py = it.oy; rx = it.fx; ry = it.fy;
    h.found = 0;
    h.wall = 0;
    a1 = ry - py;
    b1 = px - rx;
    c1 = a1 * px + b1 * py;
    for (int i = 0; i < walls_used; i++) begin
      a2 = wy2[i] - wy1[i];
      b2 = wx1[i] - wx2[i];
      c2 = a2 * wx1[i] + b2 * wy1[i];
      det = a1 * b2 - a2 * b1;
      if (det == 0) continue;
      tx = (b2 * c1 - b1 * c2) / det;
      ty = (a1 * c2 - a2 * c1) / det;
      xmin = (wx1[i] < wx2[i]) ? wx1[i] : wx2[i];
      xmax = (wx1[i] > wx2[i]) ? wx1[i] : wx2[i];
      ymin = (wy1[i] < wy2[i]) ? wy1[i] : wy2[i];
      ymax = (wy1[i] > wy2[i]) ? wy1[i] : wy2[i];
      xin = tx > xmin && tx < xmax;
      yin = ty > ymin && ty < ymax;
      if (xmax == xmin) boxed = yin;
      else if (ymax == ymin) boxed = xin;
      else boxed = xin && yin;
      if (!boxed) continue;
      dx = tx - px;
      dy = ty - py;
      if (dx * dx + dy * dy >= (rx - px) * (rx - px) + (ry - py) * (ry - py)) continue;
      if (dx * longint'(it.cx) + dy * longint'(it.cy) <= 0) continue;
      rx = tx;
      ry = ty;
      h.found = 1;
      h.wall = i[5:0];
    end
    h.hx = rx[15:0];
    h.hy = ry[15:0];
    hits_due.push_back(h);
  endfunction

  function void check_result(logic [39:0] data, logic found);
    hit_t e;
    if (hits_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h found=%b", data, found);
      return;
    end
    e = hits_due.pop_front();
    if (data[15:0] !== e.hx || data[31:16] !== e.hy || data[37:32] !== e.wall ||
        found !== e.found) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp x=%h y=%h wall=%0d found=%b, got x=%h y=%h wall=%0d found=%b",
                 e.hx, e.hy, e.wall, e.found, data[15:0], data[31:16], data[37:32], found);
    end
  endfunction
endclass

module tb_top;
  import rsnh_pkg::*;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_tvalid = 0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 0;
  logic                out_tvalid;
  logic                out_tready = 0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                cfg_we = 0;
  logic [CountW-1:0]   cfg_wdata = '0;

  hit_scoreboard sb = new();
  int  cycles = 0;
  bit  no_idle = 0;
  bit  hold_req = 0;
  int  wall_count_now = 0;

  always #6 clk = ~clk;

  ray_segment_nearest_hit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] rnd16(int span);
    if (span == 0) return 16'($urandom);
    return 16'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic ray_item_t wall_item(int i, int x1, int y1, int x2, int y2);
    ray_item_t it;
    it = '{default: '0};
    it.func = FuncWrite;
    it.idx = 6'(i);
    it.x1 = 16'(x1); it.y1 = 16'(y1); it.x2 = 16'(x2); it.y2 = 16'(y2);
    return it;
  endfunction

  function automatic ray_item_t cast_item(int ox, int oy, int fx, int fy, int cx, int cy);
    ray_item_t it;
    it = '{default: '0};
    it.func = FuncCast;
    it.ox = 16'(ox); it.oy = 16'(oy); it.fx = 16'(fx); it.fy = 16'(fy);
    it.cx = 16'(cx); it.cy = 16'(cy);
    return it;
  endfunction

  task automatic send_item(ray_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(11);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= it.func;
    in_tdata <= {2'd0, it.cy, it.cx, it.fy, it.fx, it.oy, it.ox,
                 it.y2, it.x2, it.y1, it.x1, it.idx};
    do @(posedge clk); while (!in_tready);
    sb.note_input(it);
  endtask

  // Drain all casts, then let a trailing wall write settle.
  task automatic wait_idle();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.hits_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [6:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_count(v);
    wall_count_now = (v > 64) ? 64 : v;
    @(posedge clk);
  endtask

  // Aim a ray through a point of a stored wall, or send noise.
  function automatic ray_item_t random_cast();
    ray_item_t it;
    longint mx, my, ox, oy;
    int     t, span;
    if (wall_count_now == 0 || $urandom_range(9) < 2)
      return cast_item(rnd16(0), rnd16(0), rnd16(0), rnd16(0), rnd16(0), rnd16(0));
    t = $urandom_range(wall_count_now - 1);
    span = $urandom_range(3) == 0 ? 16000 : 3000;
    mx = (sb.wx1[t] + sb.wx2[t]) / 2 + (int'($urandom_range(40)) - 20);
    my = (sb.wy1[t] + sb.wy2[t]) / 2 + (int'($urandom_range(40)) - 20);
    ox = rnd16(span);
    oy = rnd16(span);
    it = cast_item(ox, oy, sat16(ox + 2 * (mx - ox)), sat16(oy + 2 * (my - oy)), 0, 0);
    it.cx = sat16(it.fx - ox);
    it.cy = sat16(it.fy - oy);
    if ($urandom_range(7) == 0) begin
      it.cx = -it.cx;
      it.cy = -it.cy;
    end
    return it;
  endfunction

  function automatic ray_item_t random_wall();
    int span;
    span = $urandom_range(4) == 0 ? 0 : 3000;
    return wall_item($urandom_range(63), rnd16(span), rnd16(span), rnd16(span), rnd16(span));
  endfunction

  // Receiver: random stalls, stretches without stalls, one long hold-off on request.
  initial begin : receiver
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 0;
        repeat (3000) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(11);
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tuser);
    end
  end

  initial begin : stimulus
    int counts[13] = '{1, 2, 3, 4, 8, 0, 5, 2, 64, 127, 7, 16, 3};
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Special walls: vertical, horizontal, point, extreme diagonals.
    send_item(wall_item(0, 100, -200, 100, 200));
    send_item(wall_item(1, -300, 50, 300, 50));
    send_item(wall_item(2, 10, 10, 10, 10));
    send_item(wall_item(3, -32768, -32768, 32767, 32767));
    send_item(wall_item(4, 32767, -32768, -32768, 32767));
    send_item(wall_item(5, 400, -100, 500, 100));
    for (int i = 6; i < 64; i++) begin
      send_item(wall_item(i, rnd16(3000), rnd16(3000), rnd16(3000), rnd16(3000)));
    end
    // Count still at reset: the far point comes back.
    send_item(cast_item(0, 0, 1000, 0, 16, 0));
    wait_idle();
    write_count(6);
    send_item(cast_item(0, 0, 1000, 0, 16, 0));
    send_item(cast_item(0, 0, 1000, 0, -16, 0));
    send_item(cast_item(0, 0, 0, 1000, 0, 16));
    send_item(cast_item(0, 0, 1000, 20, 16, 0));
    send_item(cast_item(-1000, 0, 1000, 0, 32767, -32768));
    send_item(cast_item(0, -1000, 0, 1000, 0, 16));
    send_item(cast_item(10, 0, 10, 1000, 0, 16));
    send_item(cast_item(-32768, 32767, 32767, -32768, 32767, -32768));
    send_item(cast_item(32767, 32767, -32768, -32768, -32768, -32768));
    send_item(cast_item(0, 0, 0, 0, 0, 0));
    send_item(cast_item(1000, 0, 0, 0, -16, 0));
    wait_idle();

    for (int p = 0; p < 13; p++) begin
      write_count(counts[p]);
      no_idle = (p % 4 == 2);
      if (p == 0) hold_req = 1;
      n = (counts[p] >= 16) ? 8 : 65;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(3) == 0) send_item(random_wall());
        else send_item(random_cast());
      end
      wait_idle();
    end
    no_idle = 0;
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.hits_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
